[rtl/q4bda_pkg.sv]
// Shared types, constants and float32 helper functions for q4_block_dot_accumulate.
// No dependencies.
`default_nettype none
package q4bda_pkg;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [30:0] INF_MAG   = 31'h7F80_0000;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL_AW,
        OP_MUL_PS,
        OP_MUL_NORM,
        OP_MUL_ROUND,
        OP_ADD_ALIGN,
        OP_ADD_NORM,
        OP_ADD_ROUND,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_AW,
        ST_MUL_AW_N,
        ST_MUL_AW_R,
        ST_MUL_PS,
        ST_MUL_PS_N,
        ST_MUL_PS_R,
        ST_ADD,
        ST_ADD_N,
        ST_ADD_R,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
        logic   half;   // 0: low nibble term, 1: high nibble term
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy; // result register full and not taken this cycle
        logic last;     // held item closes the dot product
    } dp_status_t;

    // Half to single, exact; subnormals normalised, inf/NaN payload kept.
    function automatic logic [31:0] h2f(input logic [15:0] h);
        logic [31:0] r;
        logic [4:0]  e;
        logic [9:0]  m;
        logic [9:0]  fr;
        logic [3:0]  p;
        e = h[14:10];
        m = h[9:0];
        p = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (m[i])
                p = 4'(i);
        end
        fr = 10'(m << (4'd10 - p));
        if (e == 5'd0)
        begin
            if (m == 10'd0)
                r = {h[15], 31'd0};
            else
                r = {h[15], 8'(8'd103 + {4'd0, p}), fr, 13'd0};
        end
        else if (e == 5'd31)
            r = {h[15], INF_MAG[30:23], m, 13'd0};
        else
            r = {h[15], 8'({3'd0, e} + 8'd112), m, 13'd0};
        return r;
    endfunction

    // Nibble minus 8 as float32 (exact, -8..7).
    function automatic logic [31:0] w2f(input logic [3:0] nib);
        logic [31:0] r;
        logic [3:0]  mag;
        logic        s;
        logic [4:0]  p;
        logic [22:0] fr;
        s   = ~nib[3];
        mag = s ? 4'(4'd8 - nib) : 4'(nib - 4'd8);
        p   = 5'd0;
        for (int i = 0; i < 4; i++)
        begin
            if (mag[i])
                p = 5'(i);
        end
        fr = 23'({19'd0, mag} << (5'd23 - p));
        if (mag == 4'd0)
            r = 32'd0;
        else
            r = {s, 8'(8'd127 + {3'd0, p}), fr};
        return r;
    endfunction

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] lz;
        lz = 6'd0;
        for (int i = 0; i < 48; i++)
        begin
            if (v[i])
                lz = 6'(47 - i);
        end
        return lz;
    endfunction

    function automatic logic [4:0] lzc28(input logic [27:0] v);
        logic [4:0] lz;
        lz = 5'd0;
        for (int i = 0; i < 28; i++)
        begin
            if (v[i])
                lz = 5'(27 - i);
        end
        return lz;
    endfunction

    // mant: leading one at bit 26 when normal, bits 2..0 guard and sticky.
    // Value = mant / 2^26 * 2^(exp - 127). Round to nearest even, subnormals kept.
    function automatic logic [31:0] round_pack(input logic sign,
                                              input logic signed [10:0] exp,
                                              input logic [26:0] mant);
        logic [31:0] r;
        logic [26:0] m2;
        logic [26:0] mask;
        logic [10:0] sh;
        logic [7:0]  ef;
        logic        ru;
        logic [30:0] mag;
        m2   = mant;
        ef   = exp[7:0];
        sh   = 11'(11'sd1 - exp);
        mask = ~(27'h7FF_FFFF << sh[4:0]);
        if (exp < 11'sd1)
        begin
            ef = 8'd0;
            if (sh > 11'd26)
                m2 = {26'd0, |mant};
            else
                m2 = (mant >> sh[4:0]) | {26'd0, |(mant & mask)};
        end
        ru  = m2[2] & ((|m2[1:0]) | m2[3]);
        mag = {ef, m2[25:3]} + {30'd0, ru};
        if (exp >= 11'sd255)
            r = {sign, INF_MAG};
        else
            r = {sign, mag};
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/q4bda_in_if.sv]
// Input channel interface: valid/ready with one block item as payload.
// Depends on nothing.
`default_nettype none
interface q4bda_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] scale_half;
    logic [7:0]  weight_byte;
    logic [31:0] act_low;
    logic [31:0] act_high;
    logic        last;

    modport source (output valid, scale_half, weight_byte, act_low, act_high, last,
                    input ready);
    modport sink   (input valid, scale_half, weight_byte, act_low, act_high, last,
                    output ready);
endinterface
`default_nettype wire

[rtl/q4bda_out_if.sv]
// Output channel interface: valid/ready with the finished sum as payload.
// Depends on nothing.
`default_nettype none
interface q4bda_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] sum_bits;

    modport source (output valid, sum_bits, input ready);
    modport sink   (input valid, sum_bits, output ready);
endinterface
`default_nettype wire

[rtl/q4bda_ctrl.sv]
// Sequencer for the multiply/add datapath: one command per cycle.
// Depends on q4bda_pkg.
`default_nettype none
module q4bda_ctrl
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire q4bda_pkg::dp_status_t  status,
    output q4bda_pkg::dp_cmd_t          cmd
);

    q4bda_pkg::ctrl_state_t state_reg, state_next;
    logic half_reg, half_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= q4bda_pkg::ST_IDLE;
            half_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            half_reg  <= half_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        half_next  = half_reg;
        in_ready   = 1'b0;
        cmd.op     = q4bda_pkg::OP_NOP;
        cmd.half   = half_reg;
        case (state_reg)
            q4bda_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = q4bda_pkg::OP_LOAD;
                    half_next  = 1'b0;
                    state_next = q4bda_pkg::ST_MUL_AW;
                end
            end
            q4bda_pkg::ST_MUL_AW:
            begin
                cmd.op     = q4bda_pkg::OP_MUL_AW;
                state_next = q4bda_pkg::ST_MUL_AW_N;
            end
            q4bda_pkg::ST_MUL_AW_N:
            begin
                cmd.op     = q4bda_pkg::OP_MUL_NORM;
                state_next = q4bda_pkg::ST_MUL_AW_R;
            end
            q4bda_pkg::ST_MUL_AW_R:
            begin
                cmd.op     = q4bda_pkg::OP_MUL_ROUND;
                state_next = q4bda_pkg::ST_MUL_PS;
            end
            q4bda_pkg::ST_MUL_PS:
            begin
                cmd.op     = q4bda_pkg::OP_MUL_PS;
                state_next = q4bda_pkg::ST_MUL_PS_N;
            end
            q4bda_pkg::ST_MUL_PS_N:
            begin
                cmd.op     = q4bda_pkg::OP_MUL_NORM;
                state_next = q4bda_pkg::ST_MUL_PS_R;
            end
            q4bda_pkg::ST_MUL_PS_R:
            begin
                cmd.op     = q4bda_pkg::OP_MUL_ROUND;
                state_next = q4bda_pkg::ST_ADD;
            end
            q4bda_pkg::ST_ADD:
            begin
                cmd.op     = q4bda_pkg::OP_ADD_ALIGN;
                state_next = q4bda_pkg::ST_ADD_N;
            end
            q4bda_pkg::ST_ADD_N:
            begin
                cmd.op     = q4bda_pkg::OP_ADD_NORM;
                state_next = q4bda_pkg::ST_ADD_R;
            end
            q4bda_pkg::ST_ADD_R:
            begin
                cmd.op = q4bda_pkg::OP_ADD_ROUND;
                if (!half_reg)
                begin
                    half_next  = 1'b1;
                    state_next = q4bda_pkg::ST_MUL_AW;
                end
                else if (status.last)
                    state_next = q4bda_pkg::ST_EMIT;
                else
                    state_next = q4bda_pkg::ST_IDLE;
            end
            q4bda_pkg::ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.op     = q4bda_pkg::OP_EMIT;
                    state_next = q4bda_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = q4bda_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/q4bda_datapath.sv]
// Item registers, shared float32 multiplier and adder stages, accumulator
// and result register. Depends on q4bda_pkg.
`default_nettype none
module q4bda_datapath
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire q4bda_pkg::dp_cmd_t    cmd,
    output q4bda_pkg::dp_status_t      status,
    input  wire logic [15:0]           scale_half,
    input  wire logic [7:0]            weight_byte,
    input  wire logic [31:0]           act_low,
    input  wire logic [31:0]           act_high,
    input  wire logic                  last,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [31:0]                out_sum
);

    logic [31:0] scale_reg, actl_reg, acth_reg, prod_reg, out_reg;
    logic [7:0]  wbyte_reg;
    logic        last_reg;
    logic [31:0] acc_reg, acc_next;
    logic        out_valid_reg, out_valid_next;

    // multiplier stage registers
    logic               m_spec_reg;
    logic [31:0]        m_spec_val_reg;
    logic               m_sign_reg;
    logic signed [10:0] m_exp_reg;
    logic [47:0]        m_prod_reg;
    logic [5:0]         m_lz_reg;

    // adder stage registers
    logic               a_spec_reg;
    logic [31:0]        a_spec_val_reg;
    logic               a_sign_reg;
    logic               a_zero_reg;
    logic signed [10:0] a_exp_reg;
    logic [27:0]        a_sum_reg;
    logic [4:0]         a_lz_reg;

    // ---- multiplier operand select and first stage
    logic [31:0] mop_a, mop_b;
    logic [7:0]  ea, eb, ea_e, eb_e;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, m_sign;
    logic        m_spec;
    logic [31:0] m_spec_val;
    logic [47:0] m_prod;
    logic signed [10:0] m_exp;

    always_comb
    begin
        if (cmd.op == q4bda_pkg::OP_MUL_PS)
        begin
            mop_a = prod_reg;
            mop_b = scale_reg;
        end
        else if (cmd.half)
        begin
            mop_a = acth_reg;
            mop_b = q4bda_pkg::w2f(wbyte_reg[7:4]);
        end
        else
        begin
            mop_a = actl_reg;
            mop_b = q4bda_pkg::w2f(wbyte_reg[3:0]);
        end
        ea     = mop_a[30:23];
        eb     = mop_b[30:23];
        ea_e   = (ea == 8'd0) ? 8'd1 : ea;
        eb_e   = (eb == 8'd0) ? 8'd1 : eb;
        a_nan  = (ea == 8'hFF) && (mop_a[22:0] != 23'd0);
        b_nan  = (eb == 8'hFF) && (mop_b[22:0] != 23'd0);
        a_inf  = (ea == 8'hFF) && (mop_a[22:0] == 23'd0);
        b_inf  = (eb == 8'hFF) && (mop_b[22:0] == 23'd0);
        a_zero = (mop_a[30:0] == 31'd0);
        b_zero = (mop_b[30:0] == 31'd0);
        m_sign = mop_a[31] ^ mop_b[31];
        m_spec = 1'b1;
        if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf))
            m_spec_val = q4bda_pkg::CANON_NAN;
        else if (a_inf || b_inf)
            m_spec_val = {m_sign, q4bda_pkg::INF_MAG};
        else if (a_zero || b_zero)
            m_spec_val = {m_sign, 31'd0};
        else
        begin
            m_spec     = 1'b0;
            m_spec_val = 32'd0;
        end
        m_prod = {(ea != 8'd0), mop_a[22:0]} * {(eb != 8'd0), mop_b[22:0]};
        m_exp  = $signed(11'({3'd0, ea_e}) + 11'({3'd0, eb_e}) - 11'd126);
    end

    // ---- multiplier normalise and round
    logic [47:0] m_norm;
    logic [31:0] m_result;

    always_comb
    begin
        m_norm   = m_prod_reg << m_lz_reg;
        m_result = q4bda_pkg::round_pack(m_sign_reg,
                                         m_exp_reg - $signed({5'd0, m_lz_reg}),
                                         {m_norm[47:22], |m_norm[21:0]});
        if (m_spec_reg)
            m_result = m_spec_val_reg;
    end

    // ---- adder first stage: order, align, add
    logic [31:0] ax, ay;
    logic [7:0]  ex, ey, ex_e, ey_e, d;
    logic        x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;
    logic [26:0] mx, my, my_al, al_mask;
    logic [27:0] a_sum;
    logic        a_spec;
    logic [31:0] a_spec_val;

    always_comb
    begin
        if (prod_reg[30:0] > acc_reg[30:0])
        begin
            ax = prod_reg;
            ay = acc_reg;
        end
        else
        begin
            ax = acc_reg;
            ay = prod_reg;
        end
        ex     = ax[30:23];
        ey     = ay[30:23];
        ex_e   = (ex == 8'd0) ? 8'd1 : ex;
        ey_e   = (ey == 8'd0) ? 8'd1 : ey;
        x_nan  = (ex == 8'hFF) && (ax[22:0] != 23'd0);
        y_nan  = (ey == 8'hFF) && (ay[22:0] != 23'd0);
        x_inf  = (ex == 8'hFF) && (ax[22:0] == 23'd0);
        y_inf  = (ey == 8'hFF) && (ay[22:0] == 23'd0);
        x_zero = (ax[30:0] == 31'd0);
        y_zero = (ay[30:0] == 31'd0);
        a_spec = 1'b1;
        if (x_nan || y_nan || (x_inf && y_inf && (ax[31] != ay[31])))
            a_spec_val = q4bda_pkg::CANON_NAN;
        else if (x_inf)
            a_spec_val = ax;
        else if (x_zero && y_zero)
            a_spec_val = {ax[31] & ay[31], 31'd0};
        else
        begin
            a_spec     = 1'b0;
            a_spec_val = 32'd0;
        end
        d       = ex_e - ey_e;
        mx      = {(ex != 8'd0), ax[22:0], 3'd0};
        my      = {(ey != 8'd0), ay[22:0], 3'd0};
        al_mask = ~(27'h7FF_FFFF << d[4:0]);
        if (d > 8'd26)
            my_al = {26'd0, |my};
        else
            my_al = (my >> d[4:0]) | {26'd0, |(my & al_mask)};
        if (ax[31] ^ ay[31])
            a_sum = {1'b0, mx} - {1'b0, my_al};
        else
            a_sum = {1'b0, mx} + {1'b0, my_al};
    end

    // ---- adder normalise and round; exact cancellation gives +0
    logic [27:0] a_norm;
    logic [31:0] a_result;

    always_comb
    begin
        a_norm   = a_sum_reg << a_lz_reg;
        a_result = q4bda_pkg::round_pack(a_sign_reg,
                                         a_exp_reg - $signed({6'd0, a_lz_reg}),
                                         {a_norm[27:2], |a_norm[1:0]});
        if (a_spec_reg)
            a_result = a_spec_val_reg;
        else if (a_zero_reg)
            a_result = 32'd0;
    end

    // ---- accumulator and result register
    always_comb
    begin
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        if (cmd.op == q4bda_pkg::OP_ADD_ROUND)
            acc_next = a_result;
        else if (cmd.op == q4bda_pkg::OP_EMIT)
        begin
            acc_next       = 32'd0;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            q4bda_pkg::OP_LOAD:
            begin
                scale_reg <= q4bda_pkg::h2f(scale_half);
                wbyte_reg <= weight_byte;
                actl_reg  <= act_low;
                acth_reg  <= act_high;
                last_reg  <= last;
            end
            q4bda_pkg::OP_MUL_AW, q4bda_pkg::OP_MUL_PS:
            begin
                m_spec_reg     <= m_spec;
                m_spec_val_reg <= m_spec_val;
                m_sign_reg     <= m_sign;
                m_exp_reg      <= m_exp;
                m_prod_reg     <= m_prod;
            end
            q4bda_pkg::OP_MUL_NORM:
            begin
                m_lz_reg <= q4bda_pkg::lzc48(m_prod_reg);
            end
            q4bda_pkg::OP_MUL_ROUND:
            begin
                prod_reg <= m_result;
            end
            q4bda_pkg::OP_ADD_ALIGN:
            begin
                a_spec_reg     <= a_spec;
                a_spec_val_reg <= a_spec_val;
                a_sign_reg     <= ax[31];
                a_zero_reg     <= (a_sum == 28'd0);
                a_exp_reg      <= $signed(11'({3'd0, ex_e}) + 11'd1);
                a_sum_reg      <= a_sum;
            end
            q4bda_pkg::OP_ADD_NORM:
            begin
                a_lz_reg <= q4bda_pkg::lzc28(a_sum_reg);
            end
            q4bda_pkg::OP_EMIT:
            begin
                out_reg <= acc_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status.out_busy = out_valid_reg & ~out_ready;
    assign status.last     = last_reg;
    assign out_valid       = out_valid_reg;
    assign out_sum         = out_reg;

endmodule
`default_nettype wire

[rtl/q4_block_dot_accumulate.sv]
// Q4 block dot product accumulator: float32 sum of act * (nibble - 8) * scale.
// Per item: accept, then per nibble multiply by weight, by scale and add; on
// last, an emit step waits while the result register is full. The controller
// sequences the single shared multiplier and adder and takes no new item until
// the current one is done. Reset clears the accumulator to +0 and empties the
// result register. Depends on q4bda_pkg, interfaces, q4bda_ctrl, q4bda_datapath.
`default_nettype none
module q4_block_dot_accumulate
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    q4bda_in_if.sink    in_ch,
    q4bda_out_if.source out_ch
);

    q4bda_pkg::dp_cmd_t    cmd;
    q4bda_pkg::dp_status_t status;

    // Controller: sequences each transaction through the shared units
    q4bda_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: result register decouples the output transaction from new input
    q4bda_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .scale_half  (in_ch.scale_half),
        .weight_byte (in_ch.weight_byte),
        .act_low     (in_ch.act_low),
        .act_high    (in_ch.act_high),
        .last        (in_ch.last),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_sum     (out_ch.sum_bits)
    );

endmodule
`default_nettype wire
